@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
// RFLS_ASSERT checks a property on the rising clock edge outside reset.
// RFLS_NEVER checks that an expression is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RFLS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define RFLS_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define RFLS_ASSERT(lbl, clk, rstn, prop)
`define RFLS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ sv/rfls_pkg.sv @@
package rfls_pkg;

    // Item kinds carried in the input tuser.
    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_TOGGLE = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_QUERY  = 3'd3;
    localparam logic [2:0] OP_BOOT   = 3'd4;

    // Boot modes, two bits per relay.
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_ON     = 2'd1;
    localparam logic [1:0] MODE_SAME   = 2'd2;
    localparam logic [1:0] MODE_TOGGLE = 2'd3;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_RELAY_COUNT = 3'd0;
    localparam logic [2:0] REG_INVERSE     = 3'd1;
    localparam logic [2:0] REG_WINDOW_MS   = 3'd2;
    localparam logic [2:0] REG_CHANGES     = 3'd3;
    localparam logic [2:0] REG_BOOT_MODES  = 3'd4;
    localparam logic [2:0] REG_STORED      = 3'd5;

    localparam int MASK_W = 16;   // width of the per-relay output masks
    localparam int CNT_W  = 6;    // holds a relay count up to 32

    // Item traveling down the row of relay cells, gathering results.
    typedef struct packed {
        logic [2:0]        op;
        logic [3:0]        id;
        logic              want;
        logic [CNT_W-1:0]  cnt;       // relays in use
        logic              accepted;
        logic              queried;
        logic              save;
        logic [MASK_W-1:0] switched;
        logic [MASK_W-1:0] states;
        logic [MASK_W-1:0] smask;     // boot: stored mask with toggles applied
    } t_tok;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic [MASK_W-1:0] save_mask;
        logic              save_request;
        logic [MASK_W-1:0] switched_mask;
        logic [MASK_W-1:0] relay_states;
        logic [MASK_W-1:0] pin_levels;
        logic              queried_on;
        logic              accepted;
    } t_res;

endpackage

@@ sv/relay_flood_limited_scheduler.sv @@
// Channel        Dir  Handshake                 Contents
// s_axis         in   s_axis_tvalid/tready      one request item (set, toggle, tick, ...)
// m_axis         out  m_axis_tvalid/tready      one result item per request
// APB config     in   psel/penable/pwrite       six registers at byte addresses 0..20
//
// An item entering the block passes through a row of MAX_RELAYS relay cells, one
// cell per cycle, then through a finish register into the output register; the
// row holds one item at a time, so a new item is taken only once the last result
// has moved on into the output register.
// Reset is synchronous and active low; it clears the clock, all relay state and
// loads the register defaults. A finished result waits in the output register
// while the next item is already taken in; a result that cannot leave holds the
// row until the output register frees.
`include "assert_macros.svh"

module relay_flood_limited_scheduler
    import rfls_pkg::*;
#(
    parameter int MAX_RELAYS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] relay_id, [4] want_on, rest zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] op
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] accepted, [1] queried_on, [17:2] pin_levels, [33:18] relay_states,
    // [49:34] switched_mask, [50] save_request, [66:51] save_mask, rest zero
    output logic [71:0] m_axis_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [CNT_W-1:0] MAX_L = CNT_W'(MAX_RELAYS);

    // Configuration registers.
    logic [4:0]  r_relay_count;
    logic [15:0] r_inverse;
    logic [15:0] r_window_ms;
    logic [7:0]  r_changes;
    logic [31:0] r_boot_modes;
    logic [15:0] r_stored;

    logic [2:0]  w_cfg_idx;
    logic        w_cfg_wr;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_count <= 5'd1;
            r_inverse     <= 16'hFFFF;
            r_window_ms   <= 16'd3000;
            r_changes     <= 8'd5;
            r_boot_modes  <= '0;
            r_stored      <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_RELAY_COUNT: r_relay_count <= pwdata[4:0];
                REG_INVERSE:     r_inverse     <= pwdata[15:0];
                REG_WINDOW_MS:   r_window_ms   <= pwdata[15:0];
                REG_CHANGES:     r_changes     <= pwdata[7:0];
                REG_BOOT_MODES:  r_boot_modes  <= pwdata;
                REG_STORED:      r_stored      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_RELAY_COUNT: prdata = {27'd0, r_relay_count};
            REG_INVERSE:     prdata = {16'd0, r_inverse};
            REG_WINDOW_MS:   prdata = {16'd0, r_window_ms};
            REG_CHANGES:     prdata = {24'd0, r_changes};
            REG_BOOT_MODES:  prdata = r_boot_modes;
            REG_STORED:      prdata = {16'd0, r_stored};
            default:         prdata = '0;
        endcase
    end

    // Intake: one item in flight. The millisecond clock advances as a tick
    // enters, so every cell sees the new time.
    logic                 r_busy;
    logic                 r_tok0_vld;
    t_tok                 r_tok0;
    logic [TIME_BITS-1:0] r_now;
    logic                 w_in_acc;
    logic [CNT_W-1:0]     w_cnt;

    assign s_axis_tready = !r_busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cnt         = ({1'b0, r_relay_count} > MAX_L) ? MAX_L
                                                           : {1'b0, r_relay_count};

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_tok0.op       <= s_axis_tuser;
            r_tok0.id       <= s_axis_tdata[3:0];
            r_tok0.want     <= s_axis_tdata[4];
            r_tok0.cnt      <= w_cnt;
            r_tok0.accepted <= 1'b0;
            r_tok0.queried  <= 1'b0;
            r_tok0.save     <= 1'b0;
            r_tok0.switched <= '0;
            r_tok0.states   <= '0;
            r_tok0.smask    <= r_stored;
        end
    end

    // Row of relay cells; each owns one relay and hands the item onward.
    logic [MAX_RELAYS:0] w_vld;
    t_tok                w_tok [MAX_RELAYS+1];

    assign w_vld[0] = r_tok0_vld;
    assign w_tok[0] = r_tok0;

    for (genvar k = 0; k < MAX_RELAYS; k++) begin : g_cell
        logic [1:0] w_mode;
        logic       w_stored;
        if (k < MASK_W) begin : g_cfg
            assign w_mode   = r_boot_modes[2*k +: 2];
            assign w_stored = r_stored[k];
        end else begin : g_nocfg
            // Relays beyond the register width boot off with no stored bit.
            assign w_mode   = MODE_OFF;
            assign w_stored = 1'b0;
        end
        rfls_cell #(
            .IDX       (k),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_vld    (w_vld[k]),
            .i_tok    (w_tok[k]),
            .i_now    (r_now),
            .i_fw     (r_window_ms),
            .i_fc     (r_changes),
            .i_mode   (w_mode),
            .i_stored (w_stored),
            .o_vld    (w_vld[k+1]),
            .o_tok    (w_tok[k+1])
        );
    end

    // Finished item waits here until the output register can take it.
    logic  r_fin_vld;
    t_tok  r_fin;
    logic  r_out_vld;
    t_res  r_out;
    t_res  w_res;
    logic  w_out_load;
    logic [MASK_W-1:0] w_act;

    assign w_out_load = r_fin_vld && (!r_out_vld || m_axis_tready);

    always_comb begin
        for (int b = 0; b < MASK_W; b++) begin
            w_act[b] = r_fin.cnt > CNT_W'(b);
        end
        w_res.accepted      = r_fin.accepted;
        w_res.queried_on    = r_fin.queried;
        w_res.pin_levels    = (r_fin.states ^ r_inverse) & w_act;
        w_res.relay_states  = r_fin.states;
        w_res.switched_mask = r_fin.switched;
        w_res.save_request  = r_fin.save;
        if (!r_fin.save) begin
            w_res.save_mask = '0;
        end else if (r_fin.op == OP_BOOT) begin
            w_res.save_mask = r_fin.smask;
        end else begin
            w_res.save_mask = r_fin.states;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_tok0_vld <= 1'b0;
            r_now      <= '0;
            r_fin_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_tok0_vld <= w_in_acc;
            if (w_in_acc) begin
                r_busy <= 1'b1;
                if (s_axis_tuser == OP_TICK) begin
                    r_now <= r_now + TIME_BITS'(1);
                end
            end else if (w_out_load) begin
                r_busy <= 1'b0;
            end
            if (w_vld[MAX_RELAYS]) begin
                r_fin_vld <= 1'b1;
            end else if (w_out_load) begin
                r_fin_vld <= 1'b0;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vld[MAX_RELAYS]) begin
            r_fin <= w_tok[MAX_RELAYS];
        end
        if (w_out_load) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out};

    // Checks on the item flow through the row.
    logic [MAX_RELAYS+1:0] w_all_vld;
    assign w_all_vld = {r_fin_vld, w_vld};

    `RFLS_ASSERT(a_one_item, i_clk, i_rst_n, $onehot0(w_all_vld))
    `RFLS_ASSERT(a_fin_busy, i_clk, i_rst_n, r_fin_vld |-> r_busy)
    `RFLS_ASSERT(a_load_frees, i_clk, i_rst_n, w_out_load |=> !r_busy && r_out_vld)
    `RFLS_NEVER(a_mask_no_save, i_clk, i_rst_n, r_out_vld && !r_out.save_request && (r_out.save_mask != '0))

endmodule

@@ sv/rfls_cell.sv @@
module rfls_cell
    import rfls_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  t_tok                 i_tok,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [15:0]          i_fw,
    input  logic [7:0]           i_fc,
    input  logic [1:0]           i_mode,
    input  logic                 i_stored,
    output logic                 o_vld,
    output t_tok                 o_tok
);

    localparam logic [CNT_W-1:0] IDX_L   = CNT_W'(IDX);
    localparam bit               HAS_BIT = (IDX < MASK_W);
    localparam int               BIT     = IDX % MASK_W;

    logic                 r_phys, n_phys;
    logic                 r_tgt, n_tgt;
    logic [TIME_BITS-1:0] r_ws, n_ws;
    logic [7:0]           r_wc, n_wc;
    logic [TIME_BITS-1:0] r_due, n_due;
    t_tok                 n_tok;

    logic                 act, hit, want_eff, req, st;
    logic [TIME_BITS-1:0] win_end;
    logic [7:0]           wc_inc;

    always_comb begin
        n_phys   = r_phys;
        n_tgt    = r_tgt;
        n_ws     = r_ws;
        n_wc     = r_wc;
        n_due    = r_due;
        n_tok    = i_tok;
        st       = 1'b0;
        act      = i_tok.cnt > IDX_L;
        hit      = act && ({2'b00, i_tok.id} == IDX_L);
        want_eff = (i_tok.op == OP_TOGGLE) ? !r_phys : i_tok.want;
        req      = hit && ((i_tok.op == OP_SET) || (i_tok.op == OP_TOGGLE))
                   && (r_phys != want_eff);
        win_end  = r_ws + TIME_BITS'(i_fw);
        wc_inc   = (r_wc == 8'hFF) ? r_wc : r_wc + 8'd1;

        unique case (i_tok.op)
            OP_SET, OP_TOGGLE: begin
                if (req) begin
                    n_tok.accepted = 1'b1;
                    n_tgt          = want_eff;
                    n_due          = i_now;
                    if ((i_now < r_ws) || (win_end <= i_now)) begin
                        // Window has lapsed: a fresh one opens now.
                        n_ws = i_now;
                        n_wc = 8'd1;
                    end else begin
                        n_wc = wc_inc;
                        if (wc_inc >= i_fc) begin
                            n_due = win_end;
                        end
                    end
                end
            end
            OP_TICK: begin
                if (act && (r_tgt != r_phys) && (i_now >= r_due)) begin
                    n_phys = r_tgt;
                    if (HAS_BIT) begin
                        n_tok.switched[BIT] = 1'b1;
                    end
                    if ((i_mode == MODE_SAME) || (i_mode == MODE_TOGGLE)) begin
                        n_tok.save = 1'b1;
                    end
                end
            end
            OP_QUERY: begin
                if (hit) begin
                    n_tok.queried = r_phys;
                end
            end
            OP_BOOT: begin
                if (act) begin
                    case (i_mode)
                        MODE_ON:   st = 1'b1;
                        MODE_SAME: st = i_stored;
                        MODE_TOGGLE: begin
                            st         = !i_stored;
                            n_tok.save = 1'b1;
                            if (HAS_BIT) begin
                                n_tok.smask[BIT] = !i_tok.smask[BIT];
                            end
                        end
                        default:   st = 1'b0;
                    endcase
                    n_phys = !st;
                    n_tgt  = st;
                end
            end
            default: begin
            end
        endcase

        if (HAS_BIT && act) begin
            n_tok.states[BIT] = n_phys;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phys <= 1'b0;
            r_tgt  <= 1'b0;
            r_ws   <= '0;
            r_wc   <= '0;
            r_due  <= '0;
            o_vld  <= 1'b0;
        end else begin
            o_vld <= i_vld;
            if (i_vld) begin
                r_phys <= n_phys;
                r_tgt  <= n_tgt;
                r_ws   <= n_ws;
                r_wc   <= n_wc;
                r_due  <= n_due;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            o_tok <= n_tok;
        end
    end

endmodule

@@ tb/relay_flood_limited_scheduler_tb.sv @@
`timescale 1ns / 1ps

module relay_flood_limited_scheduler_tb;
    import rfls_pkg::*;

    // Op codes 5..7 have no meaning; the block must leave its state alone on them.
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    localparam int unsigned RELAYS       = 16;
    localparam int unsigned IDLE_PCT     = 15;    // idle share of either side, in percent
    localparam int unsigned DRAIN_CYCLES = 40;    // extra wait after the last result, for the row to run empty
    localparam int unsigned HOLD_CYCLES  = 300;   // long output hold-off
    localparam int unsigned STALL_LIMIT  = 3000;  // cycles without any handshake
    localparam int unsigned PHASE_ITEMS  = 150;
    localparam int unsigned PHASES       = 11;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [3:0] relay_id, [4] want_on, rest zero
    logic [2:0]  s_axis_tuser = '0;    // [2:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] accepted, [1] queried_on, [17:2] pin_levels, [33:18] relay_states,
    // [49:34] switched_mask, [50] save_request, [66:51] save_mask, rest zero
    logic [71:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    relay_flood_limited_scheduler i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the registers, starting from their reset values.
    logic [4:0]  cfg_relay_count = 5'd1;
    logic [15:0] cfg_inverse     = 16'hFFFF;
    logic [15:0] cfg_window_ms   = 16'd3000;
    logic [7:0]  cfg_changes     = 8'd5;
    logic [31:0] cfg_boot_modes  = 32'd0;
    logic [15:0] cfg_stored      = 16'd0;

    // Predicted relay state: the millisecond clock, the physical and wanted
    // level of every relay, and each relay's flood window and switch time.
    logic [31:0] now_ms = 32'd0;
    logic [15:0] phys_on = '0;
    logic [15:0] tgt_on = '0;
    logic [31:0] win_start [RELAYS];
    logic [7:0]  win_count [RELAYS];
    logic [31:0] due_at [RELAYS];

    t_res pending_results [$];   // predicted result items, oldest first

    // Run statistics and control flags shared by the stimulus and the sides.
    int unsigned op_count [8];
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned deferred_changes = 0;
    int unsigned switching_ticks = 0;
    int unsigned save_requests = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    bit          steady = 1'b0;        // no idling on either side while set
    bit          hold_off_req = 1'b0;  // asks the receiver for a long hold-off

    function automatic int unsigned relays_in_use();
        return (cfg_relay_count > RELAYS) ? RELAYS : int'(cfg_relay_count);
    endfunction

    // A set or toggle that differs from the physical level schedules a change.
    // The first change after a window has run out opens a new window; once the
    // window has seen enough changes, the switch waits for the window's end.
    function automatic bit schedule_change(int unsigned id, logic want);
        logic [31:0] win_end;
        if (id >= relays_in_use() || phys_on[id] == want) return 1'b0;
        win_end = win_start[id] + {16'd0, cfg_window_ms};
        if (win_count[id] != 8'hFF) win_count[id] = win_count[id] + 8'd1;
        due_at[id] = now_ms;
        if (now_ms < win_start[id] || win_end <= now_ms) begin
            win_start[id] = now_ms;
            win_count[id] = 8'd1;
        end else if (win_count[id] >= cfg_changes) begin
            due_at[id] = win_end;
            deferred_changes++;
        end
        tgt_on[id] = want;
        return 1'b1;
    endfunction

    // Works out the result item of one request and advances the relay state.
    function automatic t_res compute_relay_result(logic [2:0] op, logic [3:0] id,
                                                  logic want);
        t_res        r;
        int unsigned n;
        logic [15:0] m;
        logic [16:0] used;
        logic [1:0]  mode;
        logic        st;
        r = '0;
        n = relays_in_use();
        used = (17'd1 << n) - 17'd1;
        case (op)
            OP_SET: begin
                r.accepted = schedule_change(id, want);
            end
            OP_TOGGLE: begin
                if (id < n) r.accepted = schedule_change(id, !phys_on[id]);
            end
            OP_TICK: begin
                now_ms = now_ms + 32'd1;
                // All due off-changes first, then all due on-changes.
                for (int sweep_on = 0; sweep_on < 2; sweep_on++) begin
                    for (int i = 0; i < n; i++) begin
                        if (tgt_on[i] != phys_on[i] && tgt_on[i] == (sweep_on == 1) &&
                            now_ms >= due_at[i]) begin
                            phys_on[i] = tgt_on[i];
                            r.switched_mask[i] = 1'b1;
                            mode = cfg_boot_modes[2*i +: 2];
                            if (mode == MODE_SAME || mode == MODE_TOGGLE) r.save_request = 1'b1;
                        end
                    end
                end
                if (r.switched_mask != 0) switching_ticks++;
            end
            OP_QUERY: begin
                r.queried_on = (id < n) && phys_on[id];
            end
            OP_BOOT: begin
                m = cfg_stored;
                for (int i = 0; i < n; i++) begin
                    mode = cfg_boot_modes[2*i +: 2];
                    case (mode)
                        MODE_ON:     st = 1'b1;
                        MODE_SAME:   st = m[i];
                        MODE_TOGGLE: begin
                            st = !m[i];
                            m[i] = !m[i];
                            r.save_request = 1'b1;
                        end
                        default:     st = 1'b0;
                    endcase
                    // The level is set opposite to the boot level so that the
                    // following ticks carry out the switch.
                    phys_on[i] = !st;
                    tgt_on[i] = st;
                end
                if (r.save_request) r.save_mask = m;
            end
            default: ;
        endcase
        r.relay_states = phys_on & used[15:0];
        r.pin_levels = (r.relay_states ^ cfg_inverse) & used[15:0];
        if (op == OP_TICK && r.save_request) r.save_mask = r.relay_states;
        if (r.save_request) save_requests++;
        return r;
    endfunction

    // Offers one item, waits for the handshake and records its prediction.
    // tready is looked at on the falling edge, where nothing is changing; the
    // item then moves on the following rising edge.
    task automatic send_item(input logic [2:0] op, input logic [3:0] id, input logic want);
        t_res predicted;
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, want, id};
        s_axis_tvalid <= 1'b1;
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        predicted = compute_relay_result(op, id, want);
        pending_results.insert(pending_results.size(), predicted);
        op_count[op]++;
        items_sent++;
    endtask

    // Stops offering and waits until every predicted result has come back,
    // then lets the row run empty before anything else happens.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write: a setup cycle, then an access cycle in which the register
    // is written. Only called while the block is idle.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RELAY_COUNT: cfg_relay_count = value[4:0];
            REG_INVERSE:     cfg_inverse     = value[15:0];
            REG_WINDOW_MS:   cfg_window_ms   = value[15:0];
            REG_CHANGES:     cfg_changes     = value[7:0];
            REG_BOOT_MODES:  cfg_boot_modes  = value;
            REG_STORED:      cfg_stored      = value[15:0];
            default: ;
        endcase
    endtask

    // One random stretch of traffic. Most of it is bursts of requests on one
    // relay with a few ticks in between, so that flood windows fill up and
    // deferred changes land; the rest is single requests, boots and noise.
    task automatic random_sequence();
        int unsigned n;
        int unsigned kind;
        int unsigned pick;
        int unsigned ticks;
        logic [3:0]  r;
        logic [2:0]  op;
        n = relays_in_use();
        kind = $urandom_range(99);
        if (kind < 60) begin
            r = (n != 0 && $urandom_range(9) != 0) ? 4'($urandom_range(n - 1))
                                                    : 4'($urandom_range(15));
            repeat ($urandom_range(1, 6)) begin
                op = $urandom_range(1) ? OP_TOGGLE : OP_SET;
                send_item(op, r, 1'($urandom_range(1)));
                repeat ($urandom_range(0, 2))
                    send_item(OP_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
            end
            // Enough ticks, most of the time, to run past the window's end.
            ticks = $urandom_range(0, (cfg_window_ms > 16'd28) ? 30 : int'(cfg_window_ms) + 2);
            repeat (ticks) send_item(OP_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
            if ($urandom_range(1)) send_item(OP_QUERY, r, 1'($urandom_range(1)));
        end else if (kind < 88) begin
            pick = $urandom_range(99);
            if (pick < 30)      op = OP_SET;
            else if (pick < 50) op = OP_TOGGLE;
            else if (pick < 80) op = OP_TICK;
            else if (pick < 95) op = OP_QUERY;
            else                op = OP_BOOT;
            send_item(op, 4'($urandom_range(15)), 1'($urandom_range(1)));
        end else if (kind < 95) begin
            send_item(OP_BOOT, 4'($urandom_range(15)), 1'($urandom_range(1)));
            repeat ($urandom_range(1, 4))
                send_item(OP_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
        end else begin
            send_item(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                      4'($urandom_range(15)), 1'($urandom_range(1)));
        end
    endtask

    // Reset values: one relay in use, inverted pins, default window.
    task automatic test_reset_defaults();
        send_item(OP_QUERY, 4'd0, 1'b0);
        send_item(OP_SET, 4'd0, 1'b1);
        send_item(OP_TICK, 4'd0, 1'b0);
        send_item(OP_QUERY, 4'd0, 1'b1);
        send_item(OP_SET, 4'd15, 1'b1);           // relay not in use
        send_item(OP_UNUSED_LAST, 4'hF, 1'b1);
        send_item(OP_TOGGLE, 4'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 1'b0);
    endtask

    // All relays in use, a window of a few ticks and a single change allowed,
    // so the second change inside the window is deferred to its end. The boot
    // modes cycle through off, on, same and toggle.
    task automatic test_extreme_settings();
        wait_drained();
        apb_write(REG_RELAY_COUNT, 32'd16);
        apb_write(REG_INVERSE, 32'h0000_5A5A);
        apb_write(REG_WINDOW_MS, 32'd4);
        apb_write(REG_CHANGES, 32'd1);
        apb_write(REG_BOOT_MODES, 32'hE4E4_E4E4);
        apb_write(REG_STORED, 32'h0000_A5C3);
        send_item(OP_BOOT, 4'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 1'b0);
        send_item(OP_TOGGLE, 4'd15, 1'b0);
        send_item(OP_TOGGLE, 4'd15, 1'b1);
        repeat (5) send_item(OP_TICK, 4'd0, 1'b0);
        send_item(OP_SET, 4'd15, 1'b1);
        send_item(OP_SET, 4'd15, 1'b0);
        send_item(OP_QUERY, 4'd15, 1'b0);
        send_item(OP_QUERY, 4'd0, 1'b1);
        send_item(OP_UNUSED_FIRST, 4'd10, 1'b0);
        send_item(OP_UNUSED_MID, 4'd5, 1'b1);
    endtask

    // Several register settings in turn, the extremes among them: no relay in
    // use, a count above the relay limit, the longest windows, no changes and
    // the most changes allowed. The others are small windows and low counts.
    task automatic test_random_phases();
        int unsigned stop_at;
        logic [4:0]  count_set;
        logic [15:0] window_set;
        logic [7:0]  changes_set;
        logic [15:0] inverse_set;
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            count_set   = 5'($urandom_range(1, 16));
            window_set  = 16'($urandom_range(1, 24));
            changes_set = 8'($urandom_range(1, 4));
            inverse_set = 16'($urandom);
            case (p)
                0: begin
                    count_set = 5'd16; window_set = 16'd1; changes_set = 8'd1;
                    inverse_set = 16'h0000;
                end
                1: begin
                    count_set = 5'd31; window_set = 16'd60000; changes_set = 8'd255;
                    inverse_set = 16'hFFFF;
                end
                2: count_set = 5'd0;
                3: begin
                    count_set = 5'd17; window_set = 16'd3; changes_set = 8'd0;
                end
                4: begin
                    count_set = 5'd1; window_set = 16'hFFFF; changes_set = 8'd1;
                end
                default: ;
            endcase
            apb_write(REG_RELAY_COUNT, {27'd0, count_set});
            apb_write(REG_INVERSE, {16'd0, inverse_set});
            apb_write(REG_WINDOW_MS, {16'd0, window_set});
            apb_write(REG_CHANGES, {24'd0, changes_set});
            apb_write(REG_BOOT_MODES, $urandom);
            apb_write(REG_STORED, {16'd0, 16'($urandom)});
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at) random_sequence();
        end
    endtask

    // A long stretch with no idling on either side.
    task automatic test_back_to_back();
        int unsigned stop_at;
        wait_drained();
        steady = 1'b1;
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at) random_sequence();
        steady = 1'b0;
    endtask

    // The receiver holds off for a long time while the sender keeps offering,
    // so the row and the output register fill and the input stalls.
    task automatic test_output_hold_off();
        steady = 1'b1;
        hold_off_req = 1'b1;
        repeat (20) send_item(OP_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
        steady = 1'b0;
        wait_drained();
    endtask

    // Receiver: random idling, none while steady is set, and the long
    // hold-off counted here once a test asks for it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_off_req) begin
                hold_left = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Result check. Sampled on the falling edge: a result seen here with valid
    // and ready both high is taken at the next rising edge.
    always @(negedge i_clk) begin
        t_res  got;
        t_res  want_r;
        string bad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_res'(m_axis_tdata[66:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result %0d arrived with no request outstanding", results_seen);
            end else begin
                want_r = pending_results.pop_front();
                bad = "";
                if (got.accepted !== want_r.accepted)           bad = {bad, " accepted"};
                if (got.queried_on !== want_r.queried_on)       bad = {bad, " queried_on"};
                if (got.pin_levels !== want_r.pin_levels)       bad = {bad, " pin_levels"};
                if (got.relay_states !== want_r.relay_states)   bad = {bad, " relay_states"};
                if (got.switched_mask !== want_r.switched_mask) bad = {bad, " switched_mask"};
                if (got.save_request !== want_r.save_request)   bad = {bad, " save_request"};
                if (got.save_mask !== want_r.save_mask)         bad = {bad, " save_mask"};
                if (bad != "") begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result %0d differs in%s", results_seen, bad);
                        $display("  expected acc=%b qry=%b pin=%h st=%h sw=%h sv=%b sm=%h",
                                 want_r.accepted, want_r.queried_on, want_r.pin_levels,
                                 want_r.relay_states, want_r.switched_mask,
                                 want_r.save_request, want_r.save_mask);
                        $display("  actual   acc=%b qry=%b pin=%h st=%h sw=%h sv=%b sm=%h",
                                 got.accepted, got.queried_on, got.pin_levels,
                                 got.relay_states, got.switched_mask,
                                 got.save_request, got.save_mask);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no item has moved on either side for too long.
    always @(negedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("No item moved for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < RELAYS; i++) begin
            win_start[i] = '0;
            win_count[i] = '0;
            due_at[i] = '0;
        end
        foreach (op_count[k]) op_count[k] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extreme_settings();
        test_random_phases();
        test_back_to_back();
        test_output_hold_off();
        wait_drained();

        $display("Checked %0d results for %0d items: %0d sets, %0d toggles, %0d ticks,",
                 results_seen, items_sent, op_count[OP_SET], op_count[OP_TOGGLE],
                 op_count[OP_TICK]);
        $display("%0d queries, %0d boots; %0d changes deferred, %0d switching ticks, %0d saves.",
                 op_count[OP_QUERY], op_count[OP_BOOT], deferred_changes, switching_ticks,
                 save_requests);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
